FILE: sv/rte_pkg.sv
// ----------------------------------------------------------------------------
// rte_pkg
// types and constants shared by the route table engine
// ----------------------------------------------------------------------------
package rte_pkg;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;
   localparam logic [1:0] OP_LINK   = 2'd3;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   localparam logic [31:0] CLASS_A_MASK = 32'hFF000000;
   localparam logic [31:0] CLASS_B_MASK = 32'hFFFF0000;
   localparam logic [31:0] CLASS_C_MASK = 32'hFFFFFF00;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] dest_addr;
      logic [31:0] net_mask;
      logic [31:0] gateway_addr;
      logic [2:0]  iface;
      logic [15:0] metric;
      logic        host_route;
      logic        up_flag;
      logic        reject_flag;
      logic        blackhole_flag;
      logic        link_up;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  out_iface;
      logic [31:0] out_gateway;
      logic        matched_host;
      logic        cache_hit;
      logic [5:0]  out_slot;
   } rsp_type;

   // stored route; flags are kept as separate bits
   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] mask;
      logic [31:0] gateway;
      logic [5:0]  iface;
      logic [15:0] metric;
      logic        host;
      logic        up;
      logic        reject;
      logic        blackhole;
      logic        running;
      logic [31:0] age;
   } route_type;

endpackage

FILE: sv/ipv4_route_table_engine.sv
// ----------------------------------------------------------------------------
// ipv4_route_table_engine
// route table with add, delete, lookup and link change over one route memory
// ----------------------------------------------------------------------------
//  channel   direction  handshake
//  req_*     in         start & !busy
//  rsp_*     out        rsp_valid, one cycle, no stall
//
//  every operation except a lookup answered from the cache sweeps all
//  ENTRIES slots through the route memory, one read per cycle into a
//  registered read word, then writes back at most one slot (link change
//  writes back during the sweep). a lookup that hits the cache, or that
//  finds no running route, skips the sweep. reset clears valid bits, cache
//  and counters at once. results cannot be stalled.
module ipv4_route_table_engine #(
   parameter int ENTRIES   = 64,
   parameter int IFACES    = 8,
   parameter int HASH_BITS = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rte_pkg::req_type req_data,
   output logic             rsp_valid,
   output rte_pkg::rsp_type rsp_data
);
   import rte_pkg::*;

   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_LAST  = 5'b00100,
      S_FIN   = 5'b01000,
      S_CACHE = 5'b10000
   } state_type;

   route_type mem [ENTRIES];
   route_type rd_ff;

   state_type state_ff, state_in;
   req_type   req_ff;
   logic [ENTRIES-1:0] used_ff;
   logic [AW-1:0] addr_ff, raddr_ff, best_ff, bh_ff, bn_ff;
   logic found_ff, fh_ff, fn_ff;
   route_type best_r_ff, bh_r_ff, bn_r_ff;
   logic [31:0] age_ff;
   logic [CW-1:0] run_ff;
   logic cv_ff;
   logic [AW-1:0] cs_ff;
   logic [31:0] cd_ff;
   logic rd_act_ff;
   logic rsp_v_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic free_found;
   logic [AW-1:0] free_slot;
   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int k = ENTRIES - 1; k >= 0; k--) begin
         if (!used_ff[k]) begin
            free_found = 1'b1;
            free_slot  = AW'(k);
         end
      end
   end

   function automatic logic [HASH_BITS-1:0] bucket_of(input logic [31:0] a);
      bucket_of = a[31 -: HASH_BITS];
   endfunction

   function automatic logic valid_r(input route_type r);
      valid_r = r.up && r.running && !r.reject && !r.blackhole;
   endfunction

   function automatic logic better(input route_type a, input route_type b,
                                   input logic [31:0] now);
      if (a.metric != b.metric) better = a.metric < b.metric;
      else better = (now - a.age) < (now - b.age);
   endfunction

   // cached route copy for fast hits
   route_type cr_ff;

   // candidate tests on the registered read word
   logic in_bucket, del_match, lk_host, lk_net;
   always_comb begin
      in_bucket = used_ff[raddr_ff] &&
                  bucket_of(rd_ff.dest) == bucket_of(req_ff.dest_addr);
      del_match = in_bucket && rd_ff.host == req_ff.host_route &&
                  rd_ff.dest == req_ff.dest_addr &&
                  (req_ff.net_mask == 0 || rd_ff.mask == req_ff.net_mask) &&
                  (req_ff.gateway_addr == 0 || rd_ff.gateway == req_ff.gateway_addr);
      lk_host = in_bucket && valid_r(rd_ff) && rd_ff.host &&
                rd_ff.dest == req_ff.dest_addr;
      lk_net  = in_bucket && valid_r(rd_ff) && !rd_ff.host &&
                ((rd_ff.dest ^ req_ff.dest_addr) & rd_ff.mask) == 0;
   end

   logic link_hit;
   assign link_hit = used_ff[raddr_ff] && rd_ff.iface == 6'(req_ff.iface);

   logic [31:0] add_mask;
   always_comb begin
      add_mask = req_ff.net_mask;
      if (!req_ff.host_route && req_ff.net_mask == 0) begin
         if (!req_ff.dest_addr[31]) add_mask = CLASS_A_MASK;
         else if (req_ff.dest_addr[31:30] == 2'b10) add_mask = CLASS_B_MASK;
         else if (req_ff.dest_addr[31:29] == 3'b110) add_mask = CLASS_C_MASK;
      end
   end

   route_type new_r;
   always_comb begin
      new_r.dest      = req_ff.dest_addr;
      new_r.mask      = add_mask;
      new_r.gateway   = req_ff.gateway_addr;
      new_r.iface     = 6'(req_ff.iface);
      new_r.metric    = req_ff.metric;
      new_r.host      = req_ff.host_route;
      new_r.up        = req_ff.up_flag;
      new_r.reject    = req_ff.reject_flag;
      new_r.blackhole = req_ff.blackhole_flag;
      new_r.running   = req_ff.link_up;
      new_r.age       = age_ff;
   end

   logic cache_ok;
   assign cache_ok = cv_ff && used_ff[cs_ff] && valid_r(cr_ff) &&
                     (cd_ff == req_data.dest_addr ||
                      (!cr_ff.host &&
                       ((cr_ff.dest ^ req_data.dest_addr) & cr_ff.mask) == 0));

   logic link_wr;
   route_type link_r;
   always_comb begin
      link_r = rd_ff;
      link_r.running = req_ff.link_up;
      link_wr = rd_act_ff && req_ff.opcode == OP_LINK && link_hit &&
                32'(req_ff.iface) < 32'(IFACES);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (start) begin
            if (req_data.opcode == OP_LOOKUP && (run_ff == 0 || cache_ok))
               state_in = S_CACHE;
            else state_in = S_SCAN;
         end
         S_SCAN:  if (addr_ff == AW'(ENTRIES - 1)) state_in = S_LAST;
         S_LAST:  state_in = S_FIN;
         S_FIN:   state_in = S_IDLE;
         S_CACHE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = state_ff != S_IDLE;

   // result word
   always_comb begin
      rsp_in = '0;
      rsp_in.status = ST_NOT_FOUND;
      if (state_ff == S_CACHE) begin
         if (run_ff != 0) begin
            rsp_in.status = ST_DONE;
            rsp_in.cache_hit = 1'b1;
            rsp_in.out_iface = cr_ff.iface[2:0];
            rsp_in.out_gateway = cr_ff.gateway;
            rsp_in.matched_host = cr_ff.host;
            rsp_in.out_slot = 6'(cs_ff);
         end
      end else if (state_ff == S_FIN) begin
         case (req_ff.opcode)
            OP_ADD: if (32'(req_ff.iface) < 32'(IFACES)) begin
               if (!free_found) rsp_in.status = ST_FULL;
               else begin
                  rsp_in.status = ST_DONE;
                  rsp_in.out_slot = 6'(free_slot);
               end
            end
            OP_DELETE: if (found_ff) begin
               rsp_in.status = ST_DONE;
               rsp_in.out_slot = 6'(best_ff);
            end
            OP_LOOKUP: if (fh_ff || fn_ff) begin
               rsp_in.status = ST_DONE;
               rsp_in.out_iface = fh_ff ? bh_r_ff.iface[2:0] : bn_r_ff.iface[2:0];
               rsp_in.out_gateway = fh_ff ? bh_r_ff.gateway : bn_r_ff.gateway;
               rsp_in.matched_host = fh_ff;
               rsp_in.out_slot = 6'(fh_ff ? bh_ff : bn_ff);
            end
            OP_LINK: if (32'(req_ff.iface) < 32'(IFACES)) rsp_in.status = ST_DONE;
            default: ;
         endcase
      end
   end

   // memory
   always_ff @(posedge clock) begin
      rd_ff <= mem[addr_ff];
      if (link_wr) mem[raddr_ff] <= link_r;
      else if (state_ff == S_FIN && req_ff.opcode == OP_ADD &&
               32'(req_ff.iface) < 32'(IFACES) && free_found)
         mem[free_slot] <= new_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         age_ff   <= '0;
         run_ff   <= '0;
         cv_ff    <= 1'b0;
         cs_ff    <= '0;
         cd_ff    <= '0;
         rd_act_ff <= 1'b0;
         addr_ff  <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         raddr_ff <= addr_ff;
         rd_act_ff <= state_ff == S_SCAN;
         rsp_v_ff <= (state_ff == S_CACHE) || (state_ff == S_FIN);
         rsp_ff <= rsp_in;
         case (state_ff)
            S_IDLE: begin
               addr_ff <= '0;
               found_ff <= 1'b0;
               fh_ff <= 1'b0;
               fn_ff <= 1'b0;
               if (start) begin
                  req_ff <= req_data;
                  if (req_data.opcode == OP_LOOKUP && run_ff != 0 && cache_ok)
                     cd_ff <= req_data.dest_addr;
               end
            end
            S_SCAN: if (addr_ff != AW'(ENTRIES - 1)) addr_ff <= addr_ff + 1'b1;
            default: ;
         endcase
         if (rd_act_ff) begin
            if (req_ff.opcode == OP_DELETE && del_match &&
                (!found_ff || better(rd_ff, best_r_ff, age_ff))) begin
               found_ff <= 1'b1; best_ff <= raddr_ff; best_r_ff <= rd_ff;
            end
            if (lk_host && (!fh_ff || better(rd_ff, bh_r_ff, age_ff))) begin
               fh_ff <= 1'b1; bh_ff <= raddr_ff; bh_r_ff <= rd_ff;
            end
            if (lk_net && (!fn_ff || better(rd_ff, bn_r_ff, age_ff))) begin
               fn_ff <= 1'b1; bn_ff <= raddr_ff; bn_r_ff <= rd_ff;
            end
            if (link_wr) begin
               if (req_ff.link_up) begin
                  if (!rd_ff.running) run_ff <= run_ff + 1'b1;
                  if (valid_r(link_r)) cv_ff <= 1'b0;
               end else begin
                  if (rd_ff.running && run_ff != 0) run_ff <= run_ff - 1'b1;
                  if (cs_ff == raddr_ff) cv_ff <= 1'b0;
               end
               if (cs_ff == raddr_ff) cr_ff <= link_r;
            end
         end
         if (state_ff == S_FIN) begin
            case (req_ff.opcode)
               OP_ADD: if (32'(req_ff.iface) < 32'(IFACES) && free_found) begin
                  used_ff[free_slot] <= 1'b1;
                  age_ff <= age_ff + 1'b1;
                  if (req_ff.link_up) run_ff <= run_ff + 1'b1;
                  if (valid_r(new_r)) cv_ff <= 1'b0;
               end
               OP_DELETE: if (found_ff) begin
                  used_ff[best_ff] <= 1'b0;
                  if (best_r_ff.running && run_ff != 0) run_ff <= run_ff - 1'b1;
                  if (cs_ff == best_ff) cv_ff <= 1'b0;
               end
               OP_LOOKUP: if (fh_ff || fn_ff) begin
                  cv_ff <= 1'b1;
                  cs_ff <= fh_ff ? bh_ff : bn_ff;
                  cr_ff <= fh_ff ? bh_r_ff : bn_r_ff;
                  cd_ff <= req_ff.dest_addr;
               end
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back to back result");
   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");
   a_fin_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |=> rsp_valid) else $error("missing result");
endmodule
